/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is held
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cda_pkg.sv */
`timescale 1ns / 1ps

package cda_pkg;

    localparam int MAX_YEAR    = 9999;
    localparam int CMD_W       = 3;
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int COUNT_W     = 22;
    localparam int DIFF_W      = 23;
    localparam int SERIAL_W    = 22;
    localparam int ACC_W       = SERIAL_W + 2;
    localparam int OFF_W       = 12;
    localparam int YLEN_W      = 9;

    // year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact for every 14-bit year
    localparam int RECIP_W     = 13;
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int MUL_W       = YEAR_W + RECIP_W;
    localparam int QUOT_W      = MUL_W - RECIP_SHIFT;

    localparam int LAST_SERIAL = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                                 + MAX_YEAR / 400 - 1;
    localparam int DIFF_LIMIT  = 4194303;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_DIFF  = 3'd2,
        CMD_CMP   = 3'd3,
        CMD_CHECK = 3'd4
    } op_t;

    typedef struct packed {
        logic load_in;
        logic sel_b;
        logic mul;
        logic div;
        logic term;
        logic sum;
        logic arith;
        logic year_step;
        logic rem;
        logic month_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic walk;
        logic year_more;
        logic month_more;
    } dp_stat_t;

    // days in a common year before the first of month m
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        unique case (m)
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // length of month m, zero for a month outside 1 to 12
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] v;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
            4'd2:    v = leap ? 5'd29 : 5'd28;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/cda_if.sv */
`timescale 1ns / 1ps

interface cda_req_if import cda_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [YEAR_W-1:0]    year_a;
    logic [MONTH_W-1:0]   month_a;
    logic [DAY_W-1:0]     day_a;
    logic [COUNT_W-1:0]   day_count;
    logic [YEAR_W-1:0]    year_b;
    logic [MONTH_W-1:0]   month_b;
    logic [DAY_W-1:0]     day_b;

    modport source (
        output valid, command, year_a, month_a, day_a, day_count, year_b, month_b, day_b,
        input  ready
    );
    modport sink (
        input  valid, command, year_a, month_a, day_a, day_count, year_b, month_b, day_b,
        output ready
    );
endinterface

interface cda_rsp_if import cda_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [YEAR_W-1:0]        result_year;
    logic [MONTH_W-1:0]       result_month;
    logic [DAY_W-1:0]         result_day;
    logic signed [DIFF_W-1:0] day_difference;
    logic                     is_less;
    logic                     is_equal;
    logic                     is_greater;
    logic                     date_valid;
    logic                     out_of_range;

    modport source (
        output valid, result_year, result_month, result_day, day_difference,
               is_less, is_equal, is_greater, date_valid, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, result_year, result_month, result_day, day_difference,
               is_less, is_equal, is_greater, date_valid, out_of_range,
        output ready
    );
endinterface

/* hdl/cda_ctrl.sv */
`timescale 1ns / 1ps

module cda_ctrl import cda_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output dp_cmd_t  ctl,
    input  dp_stat_t stat
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL   = 9'b000000010,
        ST_DIV   = 9'b000000100,
        ST_TERM  = 9'b000001000,
        ST_SUM   = 9'b000010000,
        ST_ARITH = 9'b000100000,
        ST_YEAR  = 9'b001000000,
        ST_MONTH = 9'b010000000,
        ST_FIN   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_b_reg, sel_b_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        sel_b_next = sel_b_reg;
        ctl        = '0;
        ctl.sel_b  = sel_b_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load_in = 1'b1;
                    sel_b_next  = 1'b0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                ctl.div    = 1'b1;
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                ctl.term   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                ctl.sum = 1'b1;
                // serial of date A done, go round again for date B
                if (!sel_b_reg)
                begin
                    sel_b_next = 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_ARITH;
                end
            end
            ST_ARITH:
            begin
                ctl.arith  = 1'b1;
                state_next = stat.walk ? ST_YEAR : ST_FIN;
            end
            ST_YEAR:
            begin
                if (stat.year_more)
                begin
                    ctl.year_step = 1'b1;
                end
                else
                begin
                    ctl.rem    = 1'b1;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (stat.month_more)
                begin
                    ctl.month_step = 1'b1;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = ctl.load_out | (rsp_valid_reg & ~rsp_ready);
    assign req_ready      = (state_reg == ST_IDLE);
    assign rsp_valid      = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_b_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_b_reg     <= sel_b_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

/* hdl/cda_datapath.sv */
`timescale 1ns / 1ps

module cda_datapath import cda_pkg::*; (
    input  logic                     clk,
    input  dp_cmd_t                  ctl,
    output dp_stat_t                 stat,
    input  logic [CMD_W-1:0]         command,
    input  logic [YEAR_W-1:0]        year_a,
    input  logic [MONTH_W-1:0]       month_a,
    input  logic [DAY_W-1:0]         day_a,
    input  logic [COUNT_W-1:0]       day_count,
    input  logic [YEAR_W-1:0]        year_b,
    input  logic [MONTH_W-1:0]       month_b,
    input  logic [DAY_W-1:0]         day_b,
    output logic [YEAR_W-1:0]        result_year,
    output logic [MONTH_W-1:0]       result_month,
    output logic [DAY_W-1:0]         result_day,
    output logic signed [DIFF_W-1:0] day_difference,
    output logic                     is_less,
    output logic                     is_equal,
    output logic                     is_greater,
    output logic                     date_valid,
    output logic                     out_of_range
);

    // captured command
    logic [CMD_W-1:0]    op_reg;
    logic [YEAR_W-1:0]   ya_reg, yb_reg;
    logic [MONTH_W-1:0]  ma_reg, mb_reg;
    logic [DAY_W-1:0]    da_reg, db_reg;
    logic [COUNT_W-1:0]  cnt_reg;

    // date-to-serial unit, shared by A and B
    logic [MUL_W-1:0]    mul_reg;
    logic [QUOT_W-1:0]   q_reg;
    logic                leap_reg;
    logic                rz_reg;
    logic [ACC_W-1:0]    t1_reg;
    logic [OFF_W-1:0]    t2_reg;
    logic                va_reg, vb_reg;
    logic [SERIAL_W-1:0] ser_a_reg, ser_b_reg;

    // serial-to-date walk
    logic [SERIAL_W-1:0] n_reg;
    logic [SERIAL_W-1:0] base_reg;
    logic [YEAR_W-1:0]   yy_reg;
    logic [1:0]          c4_reg;
    logic [6:0]          c100_reg;
    logic [1:0]          cq_reg;
    logic [MONTH_W-1:0]  mm_reg;

    logic                oor_reg;
    logic [DIFF_W-1:0]   diff_reg;

    // output register
    logic [YEAR_W-1:0]   result_year_reg;
    logic [MONTH_W-1:0]  result_month_reg;
    logic [DAY_W-1:0]    result_day_reg;
    logic [DIFF_W-1:0]   day_difference_reg;
    logic                is_less_reg, is_equal_reg, is_greater_reg;
    logic                date_valid_reg, out_of_range_reg;

    logic [YEAR_W-1:0]   y_sel;
    logic [MONTH_W-1:0]  m_sel;
    logic [DAY_W-1:0]    d_sel;
    logic [QUOT_W-1:0]   q_w;
    logic [YEAR_W-1:0]   hund_w;
    logic                rz_w, leap_w;
    logic [YEAR_W-1:0]   p_w;
    logic [ACC_W-1:0]    t1_w;
    logic [QUOT_W-1:0]   p100_w, p400_w;
    logic [OFF_W-1:0]    t2_w;
    logic                valid_w;
    logic [ACC_W-1:0]    ser_w;

    logic                is_add, is_sub, is_diff, walk_w;
    logic [ACC_W-1:0]    sa_w, sum_add_w, sum_sub_w, dw_w;
    logic [ACC_W-1:0]    n_sat_w, d_sat_w;
    logic                n_oor_w, d_oor_w;

    logic                leap_loop;
    logic [YLEN_W-1:0]   ylen_w;
    logic [DAY_W-1:0]    mdays_w;

    logic                lt_w, eq_w, ok_w;

    assign y_sel = ctl.sel_b ? yb_reg : ya_reg;
    assign m_sel = ctl.sel_b ? mb_reg : ma_reg;
    assign d_sel = ctl.sel_b ? db_reg : da_reg;

    // century quotient and leap flag of the selected year
    assign q_w    = mul_reg[RECIP_SHIFT +: QUOT_W];
    assign hund_w = YEAR_W'(q_w) * YEAR_W'(100);
    assign rz_w   = (y_sel == hund_w);
    assign leap_w = (y_sel[1:0] == 2'd0) && (!rz_w || (q_w[1:0] == 2'd0));

    // days before the year: p*365 + p/4 - p/100 + p/400 with p = y - 1
    assign p_w    = y_sel - YEAR_W'(1);
    assign t1_w   = ACC_W'(p_w) * ACC_W'(365) + ACC_W'(p_w >> 2);
    assign p100_w = q_reg - QUOT_W'(rz_reg);
    assign p400_w = p100_w >> 2;
    assign t2_w   = OFF_W'(days_before_month(m_sel))
                  + OFF_W'(leap_reg && (m_sel > 4'd2))
                  + OFF_W'(d_sel) - OFF_W'(1)
                  + OFF_W'(p400_w) - OFF_W'(p100_w);
    assign valid_w = (y_sel != '0) && (y_sel <= YEAR_W'(MAX_YEAR))
                  && (d_sel != '0) && (d_sel <= month_days(m_sel, leap_reg));
    assign ser_w  = t1_reg + {{(ACC_W-OFF_W){t2_reg[OFF_W-1]}}, t2_reg};

    // add, subtract and difference with saturation
    assign is_add    = (op_reg == CMD_ADD);
    assign is_sub    = (op_reg == CMD_SUB);
    assign is_diff   = (op_reg == CMD_DIFF);
    assign walk_w    = va_reg && (is_add || is_sub);
    assign sa_w      = ACC_W'(ser_a_reg);
    assign sum_add_w = sa_w + ACC_W'(cnt_reg);
    assign sum_sub_w = sa_w - ACC_W'(cnt_reg);
    assign dw_w      = sa_w - ACC_W'(ser_b_reg);

    always_comb
    begin
        n_sat_w = is_add ? sum_add_w : sum_sub_w;
        n_oor_w = 1'b0;
        if (is_add && (sum_add_w > ACC_W'(LAST_SERIAL)))
        begin
            n_sat_w = ACC_W'(LAST_SERIAL);
            n_oor_w = 1'b1;
        end
        else if (is_sub && sum_sub_w[ACC_W-1])
        begin
            n_sat_w = '0;
            n_oor_w = 1'b1;
        end
    end

    always_comb
    begin
        d_sat_w = dw_w;
        d_oor_w = 1'b0;
        if ($signed(dw_w) > $signed(ACC_W'(DIFF_LIMIT)))
        begin
            d_sat_w = ACC_W'(DIFF_LIMIT);
            d_oor_w = 1'b1;
        end
        else if ($signed(dw_w) < $signed(ACC_W'(-DIFF_LIMIT)))
        begin
            d_sat_w = ACC_W'(-DIFF_LIMIT);
            d_oor_w = 1'b1;
        end
    end

    // year walk keeps year mod 4, year mod 100 and (year / 100) mod 4
    assign leap_loop = (c4_reg == 2'd0) && ((c100_reg != 7'd0) || (cq_reg == 2'd0));
    assign ylen_w    = leap_loop ? YLEN_W'(366) : YLEN_W'(365);
    assign mdays_w   = month_days(mm_reg, leap_loop);

    assign stat.walk       = walk_w;
    assign stat.year_more  = (ACC_W'(base_reg) + ACC_W'(ylen_w)) <= ACC_W'(n_reg);
    assign stat.month_more = (mm_reg < 4'd12) && (n_reg >= SERIAL_W'(mdays_w));

    // field-wise compare of the raw dates
    always_comb
    begin
        priority if (ya_reg != yb_reg)
            lt_w = (ya_reg < yb_reg);
        else if (ma_reg != mb_reg)
            lt_w = (ma_reg < mb_reg);
        else
            lt_w = (da_reg < db_reg);
    end
    assign eq_w = (ya_reg == yb_reg) && (ma_reg == mb_reg) && (da_reg == db_reg);

    always_comb
    begin
        unique case (op_reg)
            CMD_ADD, CMD_SUB, CMD_CHECK: ok_w = va_reg;
            CMD_DIFF, CMD_CMP:           ok_w = va_reg && vb_reg;
            default:                     ok_w = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            op_reg  <= command;
            ya_reg  <= year_a;
            ma_reg  <= month_a;
            da_reg  <= day_a;
            cnt_reg <= day_count;
            yb_reg  <= year_b;
            mb_reg  <= month_b;
            db_reg  <= day_b;
        end
        if (ctl.mul)
            mul_reg <= MUL_W'(y_sel) * MUL_W'(RECIP_100);
        if (ctl.div)
        begin
            q_reg    <= q_w;
            rz_reg   <= rz_w;
            leap_reg <= leap_w;
        end
        if (ctl.term)
        begin
            t1_reg <= t1_w;
            t2_reg <= t2_w;
            if (ctl.sel_b)
                vb_reg <= valid_w;
            else
                va_reg <= valid_w;
        end
        if (ctl.sum)
        begin
            if (ctl.sel_b)
                ser_b_reg <= ser_w[SERIAL_W-1:0];
            else
                ser_a_reg <= ser_w[SERIAL_W-1:0];
        end
        if (ctl.arith)
        begin
            oor_reg  <= (walk_w && n_oor_w) || (is_diff && va_reg && vb_reg && d_oor_w);
            diff_reg <= (is_diff && va_reg && vb_reg) ? d_sat_w[DIFF_W-1:0] : '0;
            base_reg <= '0;
            yy_reg   <= YEAR_W'(1);
            c4_reg   <= 2'd1;
            c100_reg <= 7'd1;
            cq_reg   <= 2'd0;
        end
        if (ctl.year_step)
        begin
            base_reg <= base_reg + SERIAL_W'(ylen_w);
            yy_reg   <= yy_reg + YEAR_W'(1);
            c4_reg   <= c4_reg + 2'd1;
            if (c100_reg == 7'd99)
            begin
                c100_reg <= 7'd0;
                cq_reg   <= cq_reg + 2'd1;
            end
            else
            begin
                c100_reg <= c100_reg + 7'd1;
            end
        end
        if (ctl.rem)
            mm_reg <= 4'd1;
        else if (ctl.month_step)
            mm_reg <= mm_reg + 4'd1;

        priority if (ctl.arith)
            n_reg <= n_sat_w[SERIAL_W-1:0];
        else if (ctl.rem)
            n_reg <= n_reg - base_reg;
        else if (ctl.month_step)
            n_reg <= n_reg - SERIAL_W'(mdays_w);
        else
            n_reg <= n_reg;

        if (ctl.load_out)
        begin
            if (walk_w)
            begin
                result_year_reg  <= yy_reg;
                result_month_reg <= mm_reg;
                result_day_reg   <= n_reg[DAY_W-1:0] + DAY_W'(1);
            end
            else
            begin
                result_year_reg  <= ya_reg;
                result_month_reg <= ma_reg;
                result_day_reg   <= da_reg;
            end
            day_difference_reg <= diff_reg;
            is_less_reg        <= (op_reg == CMD_CMP) && lt_w;
            is_equal_reg       <= (op_reg == CMD_CMP) && eq_w;
            is_greater_reg     <= (op_reg == CMD_CMP) && !lt_w && !eq_w;
            date_valid_reg     <= ok_w;
            out_of_range_reg   <= oor_reg;
        end
    end

    assign result_year    = result_year_reg;
    assign result_month   = result_month_reg;
    assign result_day     = result_day_reg;
    assign day_difference = $signed(day_difference_reg);
    assign is_less        = is_less_reg;
    assign is_equal       = is_equal_reg;
    assign is_greater     = is_greater_reg;
    assign date_valid     = date_valid_reg;
    assign out_of_range   = out_of_range_reg;

endmodule

/* hdl/calendar_date_arithmetic_top.sv */
`timescale 1ns / 1ps

// Gregorian date calculator: one command per transfer on req, one result per transfer
// on rsp. It adds or subtracts a day count to date A, gives the signed days from date B
// to date A, compares A with B field by field, or checks date A; dates run from
// 0001-01-01 to MAX_YEAR-12-31 and a result past either end saturates and raises
// out_of_range. Both dates are first turned into day numbers, one after the other, by
// one shared unit in steps (multiply, divide, terms, sum). Add and subtract then walk
// the result back into a date one year per cycle and one month per cycle. One command
// is in work at a time; a finished result waits in the output register while the next
// command is taken.
module calendar_date_arithmetic_top import cda_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    cda_req_if.sink    req,
    cda_rsp_if.source  rsp
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    cda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl),
        .stat      (stat)
    );

    cda_datapath u_datapath (
        .clk            (clk),
        .ctl            (ctl),
        .stat           (stat),
        .command        (req.command),
        .year_a         (req.year_a),
        .month_a        (req.month_a),
        .day_a          (req.day_a),
        .day_count      (req.day_count),
        .year_b         (req.year_b),
        .month_b        (req.month_b),
        .day_b          (req.day_b),
        .result_year    (rsp.result_year),
        .result_month   (rsp.result_month),
        .result_day     (rsp.result_day),
        .day_difference (rsp.day_difference),
        .is_less        (rsp.is_less),
        .is_equal       (rsp.is_equal),
        .is_greater     (rsp.is_greater),
        .date_valid     (rsp.date_valid),
        .out_of_range   (rsp.out_of_range)
    );

endmodule

/* hdl/cda_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cda_checker import cda_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [YEAR_W-1:0]        result_year,
    input logic signed [DIFF_W-1:0] day_difference,
    input logic                     is_less,
    input logic                     is_equal,
    input logic                     is_greater,
    input logic                     date_valid,
    input logic                     out_of_range
);

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, (rsp_valid && !rsp_ready), (rsp_valid && $stable(result_year) && $stable(day_difference)), "result dropped or changed while stalled")

    `ASSERT_NEXT(a_one_in_work, clk, rst_n, (req_valid && req_ready), (!req_ready), "second command taken while one is in work")

    `ASSERT_IMPL(a_cmp_exclusive, clk, rst_n, rsp_valid, ($onehot0({is_less, is_equal, is_greater})), "more than one compare flag set")

    `ASSERT_IMPL(a_flags_need_valid, clk, rst_n, (rsp_valid && (out_of_range || (day_difference != '0))), date_valid, "range flag or difference on invalid dates")

endmodule

bind calendar_date_arithmetic_top cda_checker u_cda_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .result_year    (rsp.result_year),
    .day_difference (rsp.day_difference),
    .is_less        (rsp.is_less),
    .is_equal       (rsp.is_equal),
    .is_greater     (rsp.is_greater),
    .date_valid     (rsp.date_valid),
    .out_of_range   (rsp.out_of_range)
);

/* bench/calendar_date_arithmetic_top_test.sv */
`timescale 1ns / 1ps

module calendar_date_arithmetic_top_test;
    import cda_pkg::*;

    // command codes the block treats as no operation
    localparam logic [CMD_W-1:0] OP_NOP_LO  = 3'd5;
    localparam logic [CMD_W-1:0] OP_NOP_MID = 3'd6;
    localparam logic [CMD_W-1:0] OP_NOP_HI  = 3'd7;

    localparam int DIRECTED_N       = 25;
    localparam int RANDOM_PER_PHASE = 22;
    localparam int BURST_N          = 8;
    localparam int LONG_STALL       = 300;
    localparam int SETTLE_CYCLES    = 100;
    localparam int CYCLE_LIMIT      = 6000000;
    localparam int YEAR_TOP         = (1 << YEAR_W) - 1;
    localparam int COUNT_TOP        = (1 << COUNT_W) - 1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [YEAR_W-1:0]  year_a;
        logic [MONTH_W-1:0] month_a;
        logic [DAY_W-1:0]   day_a;
        logic [COUNT_W-1:0] day_count;
        logic [YEAR_W-1:0]  year_b;
        logic [MONTH_W-1:0] month_b;
        logic [DAY_W-1:0]   day_b;
    } date_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]        result_year;
        logic [MONTH_W-1:0]       result_month;
        logic [DAY_W-1:0]         result_day;
        logic signed [DIFF_W-1:0] day_difference;
        logic                     is_less;
        logic                     is_equal;
        logic                     is_greater;
        logic                     date_valid;
        logic                     out_of_range;
    } date_rsp_t;

    typedef struct packed {
        date_req_t item;
        logic      typed;
        date_rsp_t want;
    } directed_row_t;

    localparam date_rsp_t NO_ANSWER = '0;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cda_req_if req_ch ();
    cda_rsp_if rsp_ch ();

    calendar_date_arithmetic_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    date_rsp_t     pending_results[$];
    directed_row_t dir_tab [DIRECTED_N];
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    bit            hold_request  = 1'b0;
    int            fault_count   = 0;
    int            cycles_run    = 0;
    int            shift_count   = 0;
    int            clipped_count = 0;
    int            diff_count    = 0;
    int            cmp_count     = 0;
    int            check_count   = 0;
    int            nop_count     = 0;

    // ---------------------------------------------------------------- calendar

    function automatic bit is_leap(input longint y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic longint month_length(input longint y, input longint m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // days from 0001-01-01 up to 1 January of year y
    function automatic longint days_before_jan1(input longint y);
        longint p;
        p = y - 1;
        return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic bit is_real_date(input longint y, input longint m, input longint d);
        if (y < 1 || y > MAX_YEAR || m < 1 || m > 12)
            return 1'b0;
        return d >= 1 && d <= month_length(y, m);
    endfunction

    function automatic longint day_serial(input longint y, input longint m, input longint d);
        longint n;
        n = days_before_jan1(y);
        for (longint k = 1; k < m; k++)
            n += month_length(y, k);
        return n + d - 1;
    endfunction

    function automatic void serial_to_date(input longint n, output longint y,
                                           output longint m, output longint d);
        longint rest;
        y = n / 366 + 1;
        while (days_before_jan1(y + 1) <= n)
            y++;
        rest = n - days_before_jan1(y);
        m = 1;
        while (m < 12 && rest >= month_length(y, m))
        begin
            rest -= month_length(y, m);
            m++;
        end
        d = rest + 1;
    endfunction

    function automatic date_rsp_t predict_date_result(input date_req_t q);
        longint    ya, ma, da, yb, mb, db, cnt;
        longint    serial, gap, last_serial, ry, rm, rd;
        bit        a_ok, b_ok;
        date_rsp_t r;
        ya  = q.year_a;
        ma  = q.month_a;
        da  = q.day_a;
        yb  = q.year_b;
        mb  = q.month_b;
        db  = q.day_b;
        cnt = q.day_count;
        a_ok = is_real_date(ya, ma, da);
        b_ok = is_real_date(yb, mb, db);
        last_serial = days_before_jan1(MAX_YEAR + 1) - 1;
        r = '0;
        r.result_year  = q.year_a;
        r.result_month = q.month_a;
        r.result_day   = q.day_a;
        case (q.command)
            CMD_ADD, CMD_SUB:
            begin
                r.date_valid = a_ok;
                if (a_ok)
                begin
                    serial = day_serial(ya, ma, da);
                    serial = (q.command == CMD_ADD) ? serial + cnt : serial - cnt;
                    // clamp to the first and last representable day
                    if (serial > last_serial)
                    begin
                        serial = last_serial;
                        r.out_of_range = 1'b1;
                    end
                    else if (serial < 0)
                    begin
                        serial = 0;
                        r.out_of_range = 1'b1;
                    end
                    serial_to_date(serial, ry, rm, rd);
                    r.result_year  = YEAR_W'(ry);
                    r.result_month = MONTH_W'(rm);
                    r.result_day   = DAY_W'(rd);
                end
            end
            CMD_DIFF:
            begin
                r.date_valid = a_ok && b_ok;
                if (a_ok && b_ok)
                begin
                    gap = day_serial(ya, ma, da) - day_serial(yb, mb, db);
                    if (gap > DIFF_LIMIT)
                    begin
                        gap = DIFF_LIMIT;
                        r.out_of_range = 1'b1;
                    end
                    else if (gap < -DIFF_LIMIT)
                    begin
                        gap = -DIFF_LIMIT;
                        r.out_of_range = 1'b1;
                    end
                    r.day_difference = DIFF_W'(gap);
                end
            end
            CMD_CMP:
            begin
                // compare raw fields, valid or not
                r.date_valid = a_ok && b_ok;
                if (ya != yb)
                    r.is_less = ya < yb;
                else if (ma != mb)
                    r.is_less = ma < mb;
                else
                    r.is_less = da < db;
                r.is_equal   = ya == yb && ma == mb && da == db;
                r.is_greater = !r.is_less && !r.is_equal;
            end
            CMD_CHECK:
                r.date_valid = a_ok;
            default:
                ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic date_req_t request(input logic [CMD_W-1:0] cmd, input int ya,
                                          input int ma, input int da, input int cnt,
                                          input int yb, input int mb, input int db);
        date_req_t q;
        q.command   = cmd;
        q.year_a    = YEAR_W'(ya);
        q.month_a   = MONTH_W'(ma);
        q.day_a     = DAY_W'(da);
        q.day_count = COUNT_W'(cnt);
        q.year_b    = YEAR_W'(yb);
        q.month_b   = MONTH_W'(mb);
        q.day_b     = DAY_W'(db);
        return q;
    endfunction

    function automatic date_rsp_t answer(input int ry, input int rm, input int rd,
                                         input int gap, input bit lt, input bit eq,
                                         input bit gt, input bit ok, input bit clip);
        date_rsp_t r;
        r.result_year    = YEAR_W'(ry);
        r.result_month   = MONTH_W'(rm);
        r.result_day     = DAY_W'(rd);
        r.day_difference = DIFF_W'(gap);
        r.is_less        = lt;
        r.is_equal       = eq;
        r.is_greater     = gt;
        r.date_valid     = ok;
        r.out_of_range   = clip;
        return r;
    endfunction

    // near keeps most years early, which keeps the date walk short
    function automatic void pick_valid_date(input bit near, output logic [YEAR_W-1:0] y,
                                            output logic [MONTH_W-1:0] m,
                                            output logic [DAY_W-1:0] d);
        int yy, mm;
        if (near && $urandom_range(0, 99) < 75)
            yy = $urandom_range(1, 400);
        else
            yy = $urandom_range(1, MAX_YEAR);
        mm = $urandom_range(1, 12);
        y = YEAR_W'(yy);
        m = MONTH_W'(mm);
        d = DAY_W'($urandom_range(1, int'(month_length(yy, mm))));
    endfunction

    function automatic date_req_t random_request();
        date_req_t q;
        int        pick;
        bit        shift;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            q.command = CMD_ADD;
        else if (pick < 54)
            q.command = CMD_SUB;
        else if (pick < 68)
            q.command = CMD_DIFF;
        else if (pick < 82)
            q.command = CMD_CMP;
        else if (pick < 94)
            q.command = CMD_CHECK;
        else
        begin
            case ($urandom_range(0, 2))
                0:       q.command = OP_NOP_LO;
                1:       q.command = OP_NOP_MID;
                default: q.command = OP_NOP_HI;
            endcase
        end
        shift = q.command == CMD_ADD || q.command == CMD_SUB;

        if ($urandom_range(0, 99) < 10)
        begin
            q.year_a  = YEAR_W'($urandom_range(0, YEAR_TOP));
            q.month_a = MONTH_W'($urandom);
            q.day_a   = DAY_W'($urandom);
        end
        else
            pick_valid_date(shift, q.year_a, q.month_a, q.day_a);

        pick = $urandom_range(0, 99);
        if (pick < 50)
            q.day_count = COUNT_W'($urandom_range(0, 400));
        else if (pick < 80)
            q.day_count = COUNT_W'($urandom_range(0, 40000));
        else
            q.day_count = COUNT_W'($urandom_range(0, COUNT_TOP));

        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            q.year_b  = YEAR_W'($urandom_range(0, YEAR_TOP));
            q.month_b = MONTH_W'($urandom);
            q.day_b   = DAY_W'($urandom);
        end
        else if (pick < 60)
        begin
            q.year_b  = q.year_a;
            q.month_b = q.month_a;
            q.day_b   = q.day_a;
            // nudge one field either way for near misses
            if (pick >= 35)
            begin
                case ($urandom_range(0, 2))
                    0:       q.year_b  = $urandom_range(0, 1) ? q.year_a + 1'b1 : q.year_a - 1'b1;
                    1:       q.month_b = $urandom_range(0, 1) ? q.month_a + 1'b1 : q.month_a - 1'b1;
                    default: q.day_b   = $urandom_range(0, 1) ? q.day_a + 1'b1 : q.day_a - 1'b1;
                endcase
            end
        end
        else
            pick_valid_date(1'b0, q.year_b, q.month_b, q.day_b);
        return q;
    endfunction

    // ---------------------------------------------------------------- request side

    task automatic offer_request(input date_req_t item, input bit typed, input date_rsp_t want);
        date_rsp_t due;
        due = typed ? want : predict_date_result(item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.command   <= item.command;
        req_ch.year_a    <= item.year_a;
        req_ch.month_a   <= item.month_a;
        req_ch.day_a     <= item.day_a;
        req_ch.day_count <= item.day_count;
        req_ch.year_b    <= item.year_b;
        req_ch.month_b   <= item.month_b;
        req_ch.day_b     <= item.day_b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_results.push_back(due);
        case (item.command)
            CMD_ADD, CMD_SUB:
            begin
                shift_count++;
                if (due.out_of_range)
                    clipped_count++;
            end
            CMD_DIFF:  diff_count++;
            CMD_CMP:   cmp_count++;
            CMD_CHECK: check_count++;
            default:   nop_count++;
        endcase
    endtask

    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------- result side

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fault_count++;
        end
    endtask

    task automatic check_result();
        date_rsp_t want;
        if (pending_results.size() == 0)
        begin
            $error("result transfer with no request outstanding");
            fault_count++;
            return;
        end
        want = pending_results.pop_front();
        check_field("result_year",    want.result_year,    rsp_ch.result_year);
        check_field("result_month",   want.result_month,   rsp_ch.result_month);
        check_field("result_day",     want.result_day,     rsp_ch.result_day);
        check_field("day_difference", want.day_difference, rsp_ch.day_difference);
        check_field("is_less",        want.is_less,        rsp_ch.is_less);
        check_field("is_equal",       want.is_equal,       rsp_ch.is_equal);
        check_field("is_greater",     want.is_greater,     rsp_ch.is_greater);
        check_field("date_valid",     want.date_valid,     rsp_ch.date_valid);
        check_field("out_of_range",   want.out_of_range,   rsp_ch.out_of_range);
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                check_result();
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_STALL;
            end
            // hold off for a long stretch so the block backs up into its input
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    initial
    begin : watchdog
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("calendar_date_arithmetic_top verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin : stimulus
        req_ch.valid     <= 1'b0;
        req_ch.command   <= '0;
        req_ch.year_a    <= '0;
        req_ch.month_a   <= '0;
        req_ch.day_a     <= '0;
        req_ch.day_count <= '0;
        req_ch.year_b    <= '0;
        req_ch.month_b   <= '0;
        req_ch.day_b     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_tab = '{
            '{request(CMD_CHECK, 1, 1, 1, 0, 0, 0, 0), 1'b1,
              answer(1, 1, 1, 0, 0, 0, 0, 1, 0)},
            '{request(CMD_CHECK, 9999, 12, 31, 0, 0, 0, 0), 1'b1,
              answer(9999, 12, 31, 0, 0, 0, 0, 1, 0)},
            '{request(CMD_CHECK, 0, 1, 1, 0, 0, 0, 0), 1'b1,
              answer(0, 1, 1, 0, 0, 0, 0, 0, 0)},
            '{request(CMD_CHECK, 2000, 2, 29, 0, 0, 0, 0), 1'b1,
              answer(2000, 2, 29, 0, 0, 0, 0, 1, 0)},
            '{request(CMD_CHECK, 1900, 2, 29, 0, 0, 0, 0), 1'b1,
              answer(1900, 2, 29, 0, 0, 0, 0, 0, 0)},
            '{request(CMD_CHECK, 2023, 4, 31, 0, 0, 0, 0), 1'b1,
              answer(2023, 4, 31, 0, 0, 0, 0, 0, 0)},
            '{request(CMD_CHECK, 2023, 0, 15, 0, 0, 0, 0), 1'b1,
              answer(2023, 0, 15, 0, 0, 0, 0, 0, 0)},
            '{request(CMD_CHECK, YEAR_TOP, 15, 31, COUNT_TOP, YEAR_TOP, 15, 31), 1'b1,
              answer(YEAR_TOP, 15, 31, 0, 0, 0, 0, 0, 0)},
            '{request(CMD_CHECK, 10000, 1, 1, 0, 0, 0, 0), 1'b1,
              answer(10000, 1, 1, 0, 0, 0, 0, 0, 0)},
            '{request(CMD_ADD, 1, 1, 1, 0, 0, 0, 0), 1'b1,
              answer(1, 1, 1, 0, 0, 0, 0, 1, 0)},
            '{request(CMD_ADD, 9999, 12, 31, COUNT_TOP, 0, 0, 0), 1'b1,
              answer(9999, 12, 31, 0, 0, 0, 0, 1, 1)},
            '{request(CMD_SUB, 1, 1, 1, 1, 0, 0, 0), 1'b1,
              answer(1, 1, 1, 0, 0, 0, 0, 1, 1)},
            '{request(CMD_ADD, 2021, 2, 29, 5, 0, 0, 0), 1'b1,
              answer(2021, 2, 29, 0, 0, 0, 0, 0, 0)},
            '{request(CMD_SUB, 0, 0, 0, COUNT_TOP, 0, 0, 0), 1'b1,
              answer(0, 0, 0, 0, 0, 0, 0, 0, 0)},
            '{request(CMD_ADD, 2024, 2, 28, 1, 0, 0, 0), 1'b0, NO_ANSWER},
            '{request(CMD_SUB, 2000, 3, 1, 1, 0, 0, 0), 1'b0, NO_ANSWER},
            '{request(CMD_SUB, 9999, 12, 31, 3652058, 0, 0, 0), 1'b0, NO_ANSWER},
            '{request(CMD_DIFF, 9999, 12, 31, 0, 1, 1, 1), 1'b1,
              answer(9999, 12, 31, 3652058, 0, 0, 0, 1, 0)},
            '{request(CMD_DIFF, 1, 1, 1, 0, 9999, 12, 31), 1'b1,
              answer(1, 1, 1, -3652058, 0, 0, 0, 1, 0)},
            '{request(CMD_DIFF, 2024, 3, 1, 0, 2023, 2, 29), 1'b1,
              answer(2024, 3, 1, 0, 0, 0, 0, 0, 0)},
            '{request(CMD_CMP, 1999, 12, 31, 0, 2000, 1, 1), 1'b1,
              answer(1999, 12, 31, 0, 1, 0, 0, 1, 0)},
            '{request(CMD_CMP, 2024, 7, 4, 0, 2024, 7, 4), 1'b1,
              answer(2024, 7, 4, 0, 0, 1, 0, 1, 0)},
            '{request(CMD_CMP, 0, 15, 31, 0, 0, 15, 30), 1'b1,
              answer(0, 15, 31, 0, 0, 0, 1, 0, 0)},
            '{request(OP_NOP_LO, 2024, 7, 4, 77, 2000, 1, 1), 1'b1,
              answer(2024, 7, 4, 0, 0, 0, 0, 0, 0)},
            '{request(OP_NOP_HI, 1, 1, 1, COUNT_TOP, 9999, 12, 31), 1'b1,
              answer(1, 1, 1, 0, 0, 0, 0, 0, 0)}
        };

        send_idle_pct = 31;
        recv_idle_pct = 74;
        foreach (dir_tab[i])
            offer_request(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
        wait_results_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 74 : 0;
            recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 31 : 0;
            if (phase == 2)
            begin
                // keep offering quick compares while the result side is held off
                hold_request = 1'b1;
                for (int k = 0; k < BURST_N; k++)
                begin
                    date_req_t quick;
                    quick = random_request();
                    quick.command = CMD_CMP;
                    offer_request(quick, 1'b0, NO_ANSWER);
                end
            end
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
                offer_request(random_request(), 1'b0, NO_ANSWER);
            wait_results_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d date shifts (%0d clipped), %0d differences, %0d compares,",
                 shift_count, clipped_count, diff_count, cmp_count);
        $display("%0d validations and %0d no-op codes in %0d cycles, %0d mismatches",
                 check_count, nop_count, cycles_run, fault_count);
        if (fault_count == 0)
            $display("calendar_date_arithmetic_top verification clean");
        else
            $display("calendar_date_arithmetic_top verification failed");
        $finish;
    end

endmodule

/* calendar_date_arithmetic_top.f */
+incdir+hdl
hdl/cda_pkg.sv
hdl/cda_if.sv
hdl/cda_ctrl.sv
hdl/cda_datapath.sv
hdl/calendar_date_arithmetic_top.sv
hdl/cda_checker.sv
bench/calendar_date_arithmetic_top_test.sv
